### hdl/bobs_pkg.sv
// shared types, constants and helpers of the block offset bitmap store
package bobs_pkg;

	localparam int BLK_W            = 32;
	localparam int OFF_W            = 16;
	localparam int WORD_BITS        = 64;
	localparam int WB_W             = 6;
	localparam int ENTRIES_DEF      = 256;
	localparam int OFFSET_LIMIT_DEF = 291;
	localparam int QDEPTH           = 2;

	typedef logic [1:0] op_t;
	typedef logic [2:0] status_t;
	typedef logic [WORD_BITS-1:0] word_t;

	localparam op_t OP_ADD     = 2'd0;
	localparam op_t OP_QUERY   = 2'd1;
	localparam op_t OP_ITER    = 2'd2;
	localparam op_t OP_RESTART = 2'd3;

	localparam status_t STS_OK       = 3'd0;
	localparam status_t STS_RANGE    = 3'd1;
	localparam status_t STS_ORDER    = 3'd2;
	localparam status_t STS_FULL     = 3'd3;
	localparam status_t STS_ITERDONE = 3'd4;

	// classified command handed from the front to the back
	typedef struct packed {
		op_t              op;
		logic [BLK_W-1:0] block;
		logic [OFF_W-1:0] offset;
		logic             last;
		logic             bad;
	} cmd_t;

	// ones at bit positions b and above
	function automatic word_t mask_from(input logic [WB_W-1:0] b);
		return ~((WORD_BITS'(1) << b) - WORD_BITS'(1));
	endfunction

	// {found, position} of the lowest set bit
	function automatic logic [WB_W:0] lowest_set(input word_t w);
		logic [WB_W:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) r = {1'b1, WB_W'(i)};
		end
		return r;
	endfunction

endpackage

### hdl/bobs_cmd_if.sv
// command channel of the block offset bitmap store
interface bobs_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] block;
	logic [15:0] offset;
	logic        last;

	modport source (output valid, op, block, offset, last, input ready);
	modport sink (input valid, op, block, offset, last, output ready);
endinterface

### hdl/bobs_rsp_if.sv
// response channel of the block offset bitmap store
interface bobs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        member;
	logic [31:0] out_block;
	logic [15:0] out_offset;
	logic        block_end;

	modport source (output valid, status, member, out_block, out_offset, block_end,
		input ready);
	modport sink (input valid, status, member, out_block, out_offset, block_end,
		output ready);
endinterface

### hdl/bobs_ram.sv
// generic single write, single registered read ram
module bobs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hdl/bobs_front.sv
// command intake: classification and a short queue toward the executor
module bobs_front import bobs_pkg::*; #(
	parameter int OFFSET_LIMIT = OFFSET_LIMIT_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	bobs_cmd_if.sink cmd,
	output logic   q_valid,
	output cmd_t   q_item,
	input  logic   q_pop
);
	localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QC_W = $clog2(QDEPTH + 1);

	cmd_t            slot_q [QDEPTH];
	logic [QP_W-1:0] wp_q;
	logic [QP_W-1:0] rp_q;
	logic [QC_W-1:0] cnt_q;
	cmd_t            incoming;
	logic            push;

	always_comb begin
		incoming.op     = cmd.op;
		incoming.block  = cmd.block;
		incoming.offset = cmd.offset;
		incoming.last   = cmd.last;
		incoming.bad    = (cmd.offset == '0) || (cmd.offset > OFF_W'(OFFSET_LIMIT));
	end

	assign cmd.ready = (cnt_q != QC_W'(QDEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_item    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= incoming;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == QP_W'(QDEPTH - 1)) ? '0 : QP_W'(wp_q + 1'b1);
			if (q_pop) rp_q <= (rp_q == QP_W'(QDEPTH - 1)) ? '0 : QP_W'(rp_q + 1'b1);
			if (push && !q_pop) cnt_q <= QC_W'(cnt_q + 1'b1);
			else if (!push && q_pop) cnt_q <= QC_W'(cnt_q - 1'b1);
		end
	end
endmodule

### hdl/bobs_back.sv
// command executor: table scans, commits, bitmap searches and the result register
module bobs_back import bobs_pkg::*; #(
	parameter int ENTRIES      = ENTRIES_DEF,
	parameter int OFFSET_LIMIT = OFFSET_LIMIT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  cmd_t      q_item,
	output logic      q_pop,
	bobs_rsp_if.source rsp
);
	localparam int MW       = OFFSET_LIMIT / WORD_BITS + 1;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int WI_W     = (MW > 1) ? $clog2(MW) : 1;
	localparam int WC_W     = $clog2(MW + 1);
	localparam int BM_DEPTH = ENTRIES * MW;
	localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
	localparam int NBW_W    = OFF_W + 1 - WB_W;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_EXEC    = 5'd1;
	localparam logic [4:0] S_SCAN    = 5'd2;
	localparam logic [4:0] S_POST    = 5'd3;
	localparam logic [4:0] S_CMT_HDR = 5'd4;
	localparam logic [4:0] S_CMT_WR  = 5'd5;
	localparam logic [4:0] S_Q_CNT   = 5'd6;
	localparam logic [4:0] S_Q_CHK   = 5'd7;
	localparam logic [4:0] S_Q_BIT   = 5'd8;
	localparam logic [4:0] S_USEMIN  = 5'd9;
	localparam logic [4:0] S_NB_CNT  = 5'd10;
	localparam logic [4:0] S_NB_LAT  = 5'd11;
	localparam logic [4:0] S_NB_RD   = 5'd12;
	localparam logic [4:0] S_NB_CHK  = 5'd13;
	localparam logic [4:0] S_ITER_RS = 5'd14;
	localparam logic [4:0] S_DONE    = 5'd15;

	localparam logic [1:0] PH_CUR  = 2'd0;
	localparam logic [1:0] PH_NEXT = 2'd1;
	localparam logic [1:0] PH_END  = 2'd2;

	logic [4:0]         state_q;
	cmd_t               cur_q;
	logic [ENTRIES-1:0] valid_q;
	word_t              pend_q [MW];
	logic [OFF_W-1:0]   plast_q;
	logic               perr_q;
	logic [BLK_W-1:0]   cur_blk_q;
	logic [OFF_W-1:0]   cur_off_q;
	logic               started_q;

	logic [CNT_W-1:0]   rd_q;
	logic               cmp_v_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic [BLK_W-1:0]   key_q;
	logic [BLK_W-1:0]   floor_q;
	logic               usefl_q;
	logic               men_q;
	logic               match_f_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic               free_f_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               min_f_q;
	logic [IDX_W-1:0]   min_idx_q;
	logic [BLK_W-1:0]   min_blk_q;

	logic [IDX_W-1:0]   nb_idx_q;
	logic [OFF_W:0]     nb_from_q;
	logic [NBW_W-1:0]   nb_w_q;
	logic [WC_W-1:0]    nb_cnt_q;
	logic               nb_f_q;
	logic [OFF_W-1:0]   nb_off_q;
	logic [1:0]         phase_q;

	logic [IDX_W-1:0]   tgt_q;
	logic [WC_W-1:0]    cw_q;

	status_t            res_status_q;
	logic               res_member_q;
	logic [BLK_W-1:0]   res_blk_q;
	logic [OFF_W-1:0]   res_off_q;
	logic               res_end_q;

	logic               out_v_q;
	status_t            out_status_q;
	logic               out_member_q;
	logic [BLK_W-1:0]   out_blk_q;
	logic [OFF_W-1:0]   out_off_q;
	logic               out_end_q;

	logic               hdr_we;
	logic               bm_we;
	logic [BLK_W-1:0]   blk_rd;
	logic [WC_W-1:0]    cnt_rd;
	word_t              bm_rd;
	logic [IDX_W-1:0]   cnt_raddr;
	logic [BM_AW-1:0]   bm_raddr;
	logic [BM_AW-1:0]   bm_waddr;
	logic [WC_W-1:0]    hdr_cnt;
	word_t              masked;
	logic [WB_W:0]      ls;
	logic               q_inrange;

	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign hdr_we  = (state_q == S_CMT_HDR);
	assign bm_we   = (state_q == S_CMT_WR);
	assign hdr_cnt = WC_W'(WC_W'(cur_q.offset[OFF_W-1:WB_W]) + WC_W'(1));
	assign bm_waddr = BM_AW'(BM_AW'(tgt_q) * BM_AW'(MW) + BM_AW'(cw_q));
	assign q_inrange = NBW_W'(cur_q.offset[OFF_W-1:WB_W]) < NBW_W'(cnt_rd);

	always_comb begin
		cnt_raddr = (state_q == S_Q_CNT) ? match_idx_q : nb_idx_q;
		if (state_q == S_Q_CHK) begin
			bm_raddr = BM_AW'(BM_AW'(match_idx_q) * BM_AW'(MW) +
				BM_AW'(cur_q.offset[OFF_W-1:WB_W]));
		end else begin
			bm_raddr = BM_AW'(BM_AW'(nb_idx_q) * BM_AW'(MW) + BM_AW'(nb_w_q));
		end
		masked = bm_rd & ((nb_w_q == nb_from_q[OFF_W:WB_W]) ?
			mask_from(nb_from_q[WB_W-1:0]) : '1);
		ls = lowest_set(masked);
	end

	bobs_ram #(.WIDTH(BLK_W), .DEPTH(ENTRIES)) u_blk_ram (
		.clk(clk), .we(hdr_we), .waddr(tgt_q), .wdata(cur_q.block),
		.raddr(rd_q[IDX_W-1:0]), .rdata(blk_rd)
	);

	bobs_ram #(.WIDTH(WC_W), .DEPTH(ENTRIES)) u_cnt_ram (
		.clk(clk), .we(hdr_we), .waddr(tgt_q), .wdata(hdr_cnt),
		.raddr(cnt_raddr), .rdata(cnt_rd)
	);

	bobs_ram #(.WIDTH(WORD_BITS), .DEPTH(BM_DEPTH)) u_bm_ram (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(pend_q[cw_q[WI_W-1:0]]),
		.raddr(bm_raddr), .rdata(bm_rd)
	);

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.member     = out_member_q;
	assign rsp.out_block  = out_blk_q;
	assign rsp.out_offset = out_off_q;
	assign rsp.block_end  = out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			valid_q      <= '0;
			for (int w = 0; w < MW; w++) pend_q[w] <= '0;
			plast_q      <= '0;
			perr_q       <= 1'b0;
			cur_blk_q    <= '0;
			cur_off_q    <= '0;
			started_q    <= 1'b0;
			rd_q         <= '0;
			cmp_v_s1     <= 1'b0;
			cmp_idx_s1   <= '0;
			key_q        <= '0;
			floor_q      <= '0;
			usefl_q      <= 1'b0;
			men_q        <= 1'b0;
			match_f_q    <= 1'b0;
			match_idx_q  <= '0;
			free_f_q     <= 1'b0;
			free_idx_q   <= '0;
			min_f_q      <= 1'b0;
			min_idx_q    <= '0;
			min_blk_q    <= '0;
			nb_idx_q     <= '0;
			nb_from_q    <= '0;
			nb_w_q       <= '0;
			nb_cnt_q     <= '0;
			nb_f_q       <= 1'b0;
			nb_off_q     <= '0;
			phase_q      <= PH_CUR;
			tgt_q        <= '0;
			cw_q         <= '0;
			res_status_q <= STS_OK;
			res_member_q <= 1'b0;
			res_blk_q    <= '0;
			res_off_q    <= '0;
			res_end_q    <= 1'b0;
			out_v_q      <= 1'b0;
			out_status_q <= STS_OK;
			out_member_q <= 1'b0;
			out_blk_q    <= '0;
			out_off_q    <= '0;
			out_end_q    <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_v_q || rsp.ready)) begin
				out_v_q      <= 1'b1;
				out_status_q <= res_status_q;
				out_member_q <= res_member_q;
				out_blk_q    <= res_blk_q;
				out_off_q    <= res_off_q;
				out_end_q    <= res_end_q;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q        <= q_item;
						res_status_q <= STS_OK;
						res_member_q <= 1'b0;
						res_blk_q    <= '0;
						res_off_q    <= '0;
						res_end_q    <= 1'b0;
						state_q      <= S_EXEC;
					end
				end
				S_EXEC: begin
					rd_q      <= '0;
					cmp_v_s1  <= 1'b0;
					match_f_q <= 1'b0;
					free_f_q  <= 1'b0;
					min_f_q   <= 1'b0;
					unique case (cur_q.op)
						OP_ADD: begin
							if (perr_q) begin
								res_status_q <= cur_q.bad ? STS_RANGE : STS_OK;
								if (cur_q.last) begin
									perr_q <= 1'b0;
									for (int w = 0; w < MW; w++) pend_q[w] <= '0;
									plast_q <= '0;
								end
								state_q <= S_DONE;
							end else if (cur_q.bad || cur_q.offset <= plast_q) begin
								for (int w = 0; w < MW; w++) pend_q[w] <= '0;
								plast_q      <= '0;
								perr_q       <= !cur_q.last;
								res_status_q <= cur_q.bad ? STS_RANGE : STS_ORDER;
								state_q      <= S_DONE;
							end else begin
								pend_q[cur_q.offset[WB_W+WI_W-1:WB_W]] <=
									pend_q[cur_q.offset[WB_W+WI_W-1:WB_W]] |
									(WORD_BITS'(1) << cur_q.offset[WB_W-1:0]);
								plast_q <= cur_q.offset;
								if (cur_q.last) begin
									key_q   <= cur_q.block;
									usefl_q <= 1'b0;
									men_q   <= 1'b1;
									state_q <= S_SCAN;
								end else begin
									state_q <= S_DONE;
								end
							end
						end
						OP_QUERY: begin
							key_q   <= cur_q.block;
							usefl_q <= 1'b0;
							men_q   <= 1'b1;
							state_q <= S_SCAN;
						end
						OP_ITER: begin
							key_q   <= cur_blk_q;
							floor_q <= cur_blk_q;
							usefl_q <= started_q;
							men_q   <= started_q;
							state_q <= S_SCAN;
						end
						default: begin
							cur_blk_q <= '0;
							cur_off_q <= '0;
							started_q <= 1'b0;
							state_q   <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					if (rd_q < CNT_W'(ENTRIES)) begin
						cmp_v_s1   <= 1'b1;
						cmp_idx_s1 <= rd_q[IDX_W-1:0];
						rd_q       <= CNT_W'(rd_q + 1'b1);
					end else begin
						cmp_v_s1 <= 1'b0;
					end
					if (cmp_v_s1) begin
						if (valid_q[cmp_idx_s1]) begin
							if (men_q && !match_f_q && blk_rd == key_q) begin
								match_f_q   <= 1'b1;
								match_idx_q <= cmp_idx_s1;
							end
							if ((!usefl_q || blk_rd > floor_q) &&
								(!min_f_q || blk_rd < min_blk_q)) begin
								min_f_q   <= 1'b1;
								min_idx_q <= cmp_idx_s1;
								min_blk_q <= blk_rd;
							end
						end else if (!free_f_q) begin
							free_f_q   <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
					end
					if (rd_q == CNT_W'(ENTRIES) && !cmp_v_s1) state_q <= S_POST;
				end
				S_POST: begin
					unique case (cur_q.op)
						OP_ADD: begin
							if (match_f_q) begin
								tgt_q   <= match_idx_q;
								state_q <= S_CMT_HDR;
							end else if (free_f_q) begin
								tgt_q   <= free_idx_q;
								state_q <= S_CMT_HDR;
							end else begin
								res_status_q <= STS_FULL;
								for (int w = 0; w < MW; w++) pend_q[w] <= '0;
								plast_q <= '0;
								state_q <= S_DONE;
							end
						end
						OP_QUERY: state_q <= match_f_q ? S_Q_CNT : S_DONE;
						default: begin
							if (men_q && match_f_q) begin
								nb_idx_q  <= match_idx_q;
								nb_from_q <= (OFF_W+1)'({1'b0, cur_off_q} + 1'b1);
								phase_q   <= PH_CUR;
								res_blk_q <= cur_blk_q;
								state_q   <= S_NB_CNT;
							end else begin
								state_q <= S_USEMIN;
							end
						end
					endcase
				end
				S_CMT_HDR: begin
					valid_q[tgt_q] <= 1'b1;
					cw_q           <= '0;
					state_q        <= S_CMT_WR;
				end
				S_CMT_WR: begin
					cw_q <= WC_W'(cw_q + 1'b1);
					if (cw_q == WC_W'(MW - 1)) begin
						for (int w = 0; w < MW; w++) pend_q[w] <= '0;
						plast_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_Q_CNT: state_q <= S_Q_CHK;
				S_Q_CHK: state_q <= q_inrange ? S_Q_BIT : S_DONE;
				S_Q_BIT: begin
					res_member_q <= bm_rd[cur_q.offset[WB_W-1:0]];
					state_q      <= S_DONE;
				end
				S_USEMIN: begin
					if (min_f_q) begin
						nb_idx_q  <= min_idx_q;
						nb_from_q <= '0;
						phase_q   <= PH_NEXT;
						res_blk_q <= min_blk_q;
						state_q   <= S_NB_CNT;
					end else begin
						res_status_q <= STS_ITERDONE;
						res_blk_q    <= '0;
						res_off_q    <= '0;
						state_q      <= S_DONE;
					end
				end
				S_NB_CNT: state_q <= S_NB_LAT;
				S_NB_LAT: begin
					nb_cnt_q <= cnt_rd;
					nb_w_q   <= nb_from_q[OFF_W:WB_W];
					state_q  <= S_NB_RD;
				end
				S_NB_RD: begin
					if (nb_w_q >= NBW_W'(nb_cnt_q)) begin
						nb_f_q  <= 1'b0;
						state_q <= S_ITER_RS;
					end else begin
						state_q <= S_NB_CHK;
					end
				end
				S_NB_CHK: begin
					if (ls[WB_W]) begin
						nb_f_q   <= 1'b1;
						nb_off_q <= OFF_W'({nb_w_q, ls[WB_W-1:0]});
						state_q  <= S_ITER_RS;
					end else begin
						nb_w_q  <= NBW_W'(nb_w_q + 1'b1);
						state_q <= S_NB_RD;
					end
				end
				S_ITER_RS: begin
					case (phase_q) inside
						PH_CUR, PH_NEXT: begin
							if (nb_f_q) begin
								res_off_q <= nb_off_q;
								nb_from_q <= (OFF_W+1)'({1'b0, nb_off_q} + 1'b1);
								phase_q   <= PH_END;
								state_q   <= S_NB_CNT;
							end else if (phase_q == PH_CUR) begin
								state_q <= S_USEMIN;
							end else begin
								// entry without bits: look further above it
								rd_q      <= '0;
								cmp_v_s1  <= 1'b0;
								match_f_q <= 1'b0;
								free_f_q  <= 1'b0;
								min_f_q   <= 1'b0;
								floor_q   <= res_blk_q;
								usefl_q   <= 1'b1;
								men_q     <= 1'b0;
								state_q   <= S_SCAN;
							end
						end
						default: begin
							res_end_q <= !nb_f_q;
							cur_blk_q <= res_blk_q;
							cur_off_q <= res_off_q;
							started_q <= 1'b1;
							state_q   <= S_DONE;
						end
					endcase
				end
				S_DONE: begin
					if (!out_v_q || rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_valid_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CMT_HDR) |=> $stable(valid_q))
		else $error("entry valid bits changed outside a commit");

	a_no_commit_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMT_HDR) |-> !perr_q)
		else $error("commit while the add sequence is aborted");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_v_q) |=> out_v_q)
		else $error("finished result not loaded into the output register");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_EXEC))
		else $error("queue popped without starting execution");
endmodule

### hdl/block_offset_bitmap_store.sv
// top level of the block offset bitmap store
// The store holds a set of (block, offset) pairs, one table entry per block with a
// bitmap of its offsets. Commands enter a two-deep queue and are executed one at a
// time. Each transaction on cmd gives exactly one transaction on rsp. An add that
// does not end a sequence, an aborted add and a restart answer without a table walk.
// A query walks the block number memory one entry per cycle and then reads the bitmap;
// a committing add walks it too, then writes the header and every bitmap word
// (OFFSET_LIMIT/64+1). An iterate takes one table walk to find the cursor's block
// and the next larger block, then up to three bitmap searches, each reading the
// word count and then the bitmap words in turn. A stalled rsp adds its stall to the
// item in flight. The store is empty after reset, with no clearing pass.
module block_offset_bitmap_store import bobs_pkg::*; #(
	parameter int ENTRIES      = ENTRIES_DEF,
	parameter int OFFSET_LIMIT = OFFSET_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bobs_cmd_if.sink   cmd,
	bobs_rsp_if.source rsp
);
	// queue between intake and executor
	logic q_valid;
	logic q_pop;
	cmd_t q_item;

	// intake: flags offsets out of range and buffers commands
	bobs_front #(.OFFSET_LIMIT(OFFSET_LIMIT)) u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	// executor: owns the table memories, pending bitmap and cursor
	bobs_back #(.ENTRIES(ENTRIES), .OFFSET_LIMIT(OFFSET_LIMIT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .rsp(rsp)
	);
endmodule

### verif/tb_block_offset_bitmap_store.sv
// testbench of the block offset bitmap store: directed table plus random traffic
`timescale 1ns / 100ps

module tb_block_offset_bitmap_store;
	import bobs_pkg::*;

	localparam int N_ENT    = ENTRIES_DEF;
	localparam int MAX_OFF  = OFFSET_LIMIT_DEF;
	localparam int N_WORDS  = MAX_OFF / WORD_BITS + 1;
	localparam int N_ITEMS  = 1850;
	localparam longint CYCLE_LIMIT = 64'd6000000;

	typedef struct packed {
		status_t     status;
		logic        member;
		logic [31:0] blk;
		logic [15:0] off;
		logic        bend;
	} rsp_t;

	typedef struct {
		op_t         op;
		logic [31:0] blk;
		logic [15:0] off;
		logic        last;
		bit          fixed;   // expected result typed in the row
		rsp_t        want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bobs_cmd_if cmd ();
	bobs_rsp_if rsp ();

	block_offset_bitmap_store i_dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	always #5 clk = ~clk;

	// predictor copy of the store
	bit          st_valid [N_ENT];
	logic [31:0] st_blk   [N_ENT];
	int          st_wc    [N_ENT];
	word_t       st_bits  [N_ENT][N_WORDS];
	word_t       pend_bits [N_WORDS];
	int          pend_last;
	bit          pend_err;
	logic [31:0] cur_blk;
	int          cur_off;
	bit          cur_started;

	rsp_t   expected_rsps [$];
	int     n_errors = 0;
	int     n_sent = 0;
	longint n_cycles = 0;
	logic [31:0] blk_pool [8];

	function automatic void clear_pend();
		foreach (pend_bits[w]) pend_bits[w] = '0;
		pend_last = 0;
	endfunction

	function automatic int find_blk(logic [31:0] b);
		for (int i = 0; i < N_ENT; i++)
			if (st_valid[i] && st_blk[i] == b) return i;
		return -1;
	endfunction

	function automatic int next_off(int idx, int from);
		for (int o = from; o < st_wc[idx] * WORD_BITS; o++)
			if (st_bits[idx][o / WORD_BITS][o % WORD_BITS]) return o;
		return -1;
	endfunction

	function automatic int next_blk(bit use_floor, logic [31:0] floor_b);
		int best;
		best = -1;
		for (int i = 0; i < N_ENT; i++) begin
			if (!st_valid[i]) continue;
			if (use_floor && st_blk[i] <= floor_b) continue;
			if (best < 0 || st_blk[i] < st_blk[best]) best = i;
		end
		return best;
	endfunction

	function automatic status_t predict_add(logic [31:0] b, int off, bit last);
		bit bad;
		int idx;
		bad = (off == 0 || off > MAX_OFF);
		if (pend_err) begin
			if (last) begin
				pend_err = 1'b0;
				clear_pend();
			end
			return bad ? STS_RANGE : STS_OK;
		end
		if (bad || off <= pend_last) begin
			clear_pend();
			pend_err = !last;
			return bad ? STS_RANGE : STS_ORDER;
		end
		pend_bits[off / WORD_BITS][off % WORD_BITS] = 1'b1;
		pend_last = off;
		if (!last) return STS_OK;
		idx = find_blk(b);
		if (idx < 0)
			for (int i = 0; i < N_ENT; i++)
				if (!st_valid[i]) begin
					idx = i;
					break;
				end
		if (idx < 0) begin
			clear_pend();
			return STS_FULL;
		end
		st_valid[idx] = 1'b1;
		st_blk[idx] = b;
		st_wc[idx] = off / WORD_BITS + 1;
		for (int w = 0; w < N_WORDS; w++) st_bits[idx][w] = pend_bits[w];
		clear_pend();
		return STS_OK;
	endfunction

	// expected response of one command, updating the predictor state
	function automatic rsp_t predict_store(op_t op, logic [31:0] b, logic [15:0] off, bit last);
		rsp_t r;
		int idx, o;
		r = '0;
		o = -1;
		case (op)
			OP_ADD: r.status = predict_add(b, off, last);
			OP_QUERY: begin
				idx = find_blk(b);
				if (idx >= 0 && off / WORD_BITS < st_wc[idx])
					r.member = st_bits[idx][off / WORD_BITS][off % WORD_BITS];
			end
			OP_ITER: begin
				if (cur_started) begin
					idx = find_blk(cur_blk);
					if (idx >= 0) o = next_off(idx, cur_off + 1);
					if (o < 0) idx = next_blk(1'b1, cur_blk);
				end else begin
					idx = next_blk(1'b0, '0);
				end
				while (o < 0 && idx >= 0) begin
					o = next_off(idx, 0);
					if (o < 0) idx = next_blk(1'b1, st_blk[idx]);
				end
				if (o < 0 || idx < 0) begin
					r.status = STS_ITERDONE;
				end else begin
					cur_blk = st_blk[idx];
					cur_off = o;
					cur_started = 1'b1;
					r.blk = cur_blk;
					r.off = o[15:0];
					r.bend = (next_off(idx, o + 1) < 0);
				end
			end
			default: begin
				cur_blk = '0;
				cur_off = 0;
				cur_started = 1'b0;
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// response checker: compare each accepted transaction with the oldest expectation
	always @(posedge clk) begin
		rsp_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.status, rsp.member, rsp.out_block, rsp.out_offset, rsp.block_end};
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response %h", $time, got);
				n_errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (got.status !== want.status)
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				if (got.member !== want.member)
					$display("%0t: member exp %0d got %0d", $time, want.member, got.member);
				if (got.blk !== want.blk)
					$display("%0t: out_block exp %h got %h", $time, want.blk, got.blk);
				if (got.off !== want.off)
					$display("%0t: out_offset exp %0d got %0d", $time, want.off, got.off);
				if (got.bend !== want.bend)
					$display("%0t: block_end exp %0d got %0d", $time, want.bend, got.bend);
				if (got !== want) n_errors++;
			end
		end
	end

	// receiver side stalls, driven at the falling edge
	initial begin
		int g;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			g = pick_gap();
			if (g == 0 || (n_cycles / 4000) % 3 == 0) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
		end
	end

	// one command transaction; the expectation is queued on acceptance
	task automatic send_cmd(op_t op, logic [31:0] b, logic [15:0] off, bit last,
			bit fixed, rsp_t want);
		rsp_t pred;
		int g;
		g = ((n_cycles / 5000) % 4 == 0) ? 0 : pick_gap();
		if (g > 0) begin
			cmd.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		cmd.valid  <= 1'b1;
		cmd.op     <= op;
		cmd.block  <= b;
		cmd.offset <= off;
		cmd.last   <= last;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		n_sent++;
		pred = predict_store(op, b, off, last);
		if (fixed && pred !== want)
			$display("%0t: table row disagrees with predictor", $time);
		expected_rsps.push_back(fixed ? want : pred);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		while (expected_rsps.size() != 0) @(negedge clk);
	endtask

	// one add sequence with random ascending offsets
	task automatic send_sequence(logic [31:0] b, int max_o);
		int o, n;
		o = 0;
		n = $urandom_range(1, 6);
		for (int k = 0; k < n; k++) begin
			o = o + $urandom_range(1, 60);
			if (o > max_o || k == n - 1) begin
				if (o > max_o) o = max_o;
				if (o <= 0) o = 1;
				send_cmd(OP_ADD, b, o[15:0], 1'b1, 1'b0, '0);
				return;
			end
			send_cmd(OP_ADD, b, o[15:0], 1'b0, 1'b0, '0);
			if (o == max_o) begin
				send_cmd(OP_ADD, b, o[15:0], 1'b1, 1'b0, '0);
				return;
			end
		end
	endtask

	initial begin
		row_t dir [$];
		rsp_t z;
		int p, max_o;
		logic [31:0] b;
		logic [15:0] off;

		z = '0;
		foreach (st_valid[i]) st_valid[i] = 1'b0;
		clear_pend();
		pend_err = 1'b0;
		cur_blk = '0;
		cur_off = 0;
		cur_started = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = OP_ADD;
		cmd.block = '0;
		cmd.offset = '0;
		cmd.last = 1'b0;

		// directed rows: op, block, offset, last, fixed, expected
		dir.push_back('{OP_ITER,    32'h0, 16'd0, 1'b0, 1, '{STS_ITERDONE, 0, 0, 0, 0}});
		dir.push_back('{OP_QUERY,   32'h0, 16'd1, 1'b0, 1, z});
		dir.push_back('{OP_ADD,     32'h0, 16'd0, 1'b0, 1, '{STS_RANGE, 0, 0, 0, 0}});
		dir.push_back('{OP_ADD,     32'h0, 16'd5, 1'b0, 1, z});
		dir.push_back('{OP_ADD,     32'h0, 16'd5, 1'b1, 1, z});
		dir.push_back('{OP_ADD,     32'h0, 16'd1, 1'b0, 1, z});
		dir.push_back('{OP_ADD,     32'h0, 16'd1, 1'b0, 1, '{STS_ORDER, 0, 0, 0, 0}});
		dir.push_back('{OP_ADD,     32'h0, 16'hFFFF, 1'b0, 1, '{STS_RANGE, 0, 0, 0, 0}});
		dir.push_back('{OP_ADD,     32'h0, 16'd9, 1'b1, 1, z});
		dir.push_back('{OP_ADD,     32'hFFFFFFFF, 16'd1, 1'b0, 0, z});
		dir.push_back('{OP_ADD,     32'hFFFFFFFF, 16'd64, 1'b0, 0, z});
		dir.push_back('{OP_ADD,     32'hFFFFFFFF, MAX_OFF[15:0], 1'b1, 1, z});
		dir.push_back('{OP_ADD,     32'h0, 16'd63, 1'b1, 1, z});
		dir.push_back('{OP_ADD,     32'h0, MAX_OFF[15:0] + 16'd1, 1'b1, 1,
			'{STS_RANGE, 0, 0, 0, 0}});
		dir.push_back('{OP_QUERY,   32'hFFFFFFFF, MAX_OFF[15:0], 1'b0, 1, '{0, 1, 0, 0, 0}});
		dir.push_back('{OP_QUERY,   32'hFFFFFFFF, 16'hFFFF, 1'b0, 1, z});
		dir.push_back('{OP_QUERY,   32'h0, 16'd63, 1'b1, 1, '{0, 1, 0, 0, 0}});
		dir.push_back('{OP_ITER,    32'h5, 16'd7, 1'b1, 1, '{0, 0, 32'h0, 16'd63, 1}});
		dir.push_back('{OP_ITER,    32'h0, 16'd0, 1'b0, 0, z});
		dir.push_back('{OP_ITER,    32'h0, 16'd0, 1'b0, 0, z});
		dir.push_back('{OP_ITER,    32'h0, 16'd0, 1'b0, 0, z});
		dir.push_back('{OP_ITER,    32'h0, 16'd0, 1'b0, 1, '{STS_ITERDONE, 0, 0, 0, 0}});
		dir.push_back('{OP_RESTART, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1, z});
		dir.push_back('{OP_ITER,    32'h0, 16'd0, 1'b0, 0, z});

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir[i])
			send_cmd(dir[i].op, dir[i].blk, dir[i].off, dir[i].last, dir[i].fixed, dir[i].want);

		// pause the sender until every response is back
		drain();

		for (int i = 0; i < 8; i++) blk_pool[i] = $urandom();
		blk_pool[0] = '0;
		blk_pool[1] = 32'hFFFFFFFF;
		while (n_sent < N_ITEMS - N_ENT - 10) begin
			p = $urandom_range(0, 99);
			b = ($urandom_range(0, 3) == 0) ? $urandom() : blk_pool[$urandom_range(0, 7)];
			if (p < 45) begin
				max_o = ($urandom_range(0, 3) == 0) ? MAX_OFF : $urandom_range(1, MAX_OFF);
				send_sequence(b, max_o);
			end else if (p < 60) begin
				off = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 300));
				send_cmd(OP_ADD, b, off, 1'($urandom()), 1'b0, z);
			end else if (p < 75) begin
				off = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 320));
				send_cmd(OP_QUERY, b, off, 1'($urandom()), 1'b0, z);
			end else if (p < 97) begin
				send_cmd(OP_ITER, $urandom(), 16'($urandom()), 1'($urandom()), 1'b0, z);
			end else begin
				send_cmd(OP_RESTART, $urandom(), 16'($urandom()), 1'($urandom()), 1'b0, z);
			end
		end

		// fill the table to reach the full condition, then keep probing it
		for (int i = 0; i < N_ENT + 4; i++)
			send_cmd(OP_ADD, 32'h8000_0000 + i, 16'd2, 1'b1, 1'b0, z);
		for (int i = 0; i < 6; i++)
			send_cmd(OP_ITER, '0, '0, 1'b0, 1'b0, z);

		drain();
		repeat (400) @(negedge clk);
		if (n_errors == 0 && expected_rsps.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
